// ===== src/cpp_pkg.sv =====
`timescale 1ns / 1ps

package cpp_pkg;

    localparam int SCREEN_WIDTH_DEF  = 400;
    localparam int SCREEN_HEIGHT_DEF = 300;

    // quotient magnitude bits below the saturation limit of 2048
    localparam int QBITS    = 11;
    localparam int SCR_W    = 12;
    localparam int WIDE_W   = 64;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_W    = 16;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_CAM_X     = 3'd0,
        REG_CAM_Y     = 3'd1,
        REG_CAM_Z     = 3'd2,
        REG_SIN_YAW   = 3'd3,
        REG_COS_YAW   = 3'd4,
        REG_SIN_PITCH = 3'd5,
        REG_COS_PITCH = 3'd6
    } t_reg_idx;

    typedef struct packed {
        logic signed [15:0] pt_x;
        logic signed [15:0] pt_y;
        logic signed [15:0] pt_z;
        logic [7:0]         red_in;
        logic [7:0]         green_in;
        logic [7:0]         blue_in;
    } t_in;

    typedef struct packed {
        logic                    visible;
        logic signed [SCR_W-1:0] screen_x;
        logic signed [SCR_W-1:0] screen_y;
        logic [7:0]              red_out;
        logic [7:0]              green_out;
        logic [7:0]              blue_out;
    } t_out;

    typedef struct packed {
        logic              neg;
        logic [WIDE_W-1:0] mag;
        logic [WIDE_W-1:0] den;
    } t_div_in;

    localparam int DIV_LAT = QBITS + 2;

endpackage

// ===== src/cpp_div.sv =====
`timescale 1ns / 1ps

module cpp_div (
    input  logic                                  i_clk,
    input  logic                                  i_en,
    input  cpp_pkg::t_div_in                      i_op,
    output logic signed [cpp_pkg::SCR_W-1:0]      o_q
);

    localparam int QB = cpp_pkg::QBITS;
    localparam int WW = cpp_pkg::WIDE_W;

    logic [WW-1:0] r_rem [QB+1];
    logic [WW-1:0] r_den [QB+1];
    logic [QB-1:0] r_q   [QB+1];
    logic          r_neg [QB+1];
    logic          r_sat [QB+1];
    logic signed [cpp_pkg::SCR_W-1:0] r_out;

    // anything at or above 2048 * den saturates
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem[0] <= i_op.mag;
            r_den[0] <= i_op.den;
            r_q[0]   <= '0;
            r_neg[0] <= i_op.neg;
            r_sat[0] <= (i_op.mag >= (i_op.den << QB));
            for (int s = 1; s <= QB; s++) begin
                r_den[s] <= r_den[s-1];
                r_neg[s] <= r_neg[s-1];
                r_sat[s] <= r_sat[s-1];
                if (r_rem[s-1] >= (r_den[s-1] << (QB - s))) begin
                    r_rem[s] <= r_rem[s-1] - (r_den[s-1] << (QB - s));
                    r_q[s]   <= r_q[s-1] | (QB'(1) << (QB - s));
                end else begin
                    r_rem[s] <= r_rem[s-1];
                    r_q[s]   <= r_q[s-1];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            if (r_sat[QB]) begin
                r_out <= r_neg[QB] ? {1'b1, {QB{1'b0}}} : {1'b0, {QB{1'b1}}};
            end else if (r_neg[QB]) begin
                r_out <= -$signed({1'b0, r_q[QB]});
            end else begin
                r_out <= $signed({1'b0, r_q[QB]});
            end
        end
    end

    assign o_q = r_out;

endmodule

// ===== src/camera_perspective_project.sv =====
`timescale 1ns / 1ps

// Camera view transform and perspective projection of one colored point per
// transfer. Points stream in at one per cycle unless the output stalls, and
// results leave in order after eight stages of subtract, rotate and scale,
// then a restoring divider that settles one quotient bit per stage (eleven
// steps plus a saturation check and a sign stage), one divider for the
// column and one for the row. A stalled output holds the whole pipeline.
// Camera registers must be written through the plain write port while no
// point is in flight; the block does not enforce this. Points with depth
// zero or less come out with visible low and zero screen coordinates.
module camera_perspective_project #(
    parameter int SCREEN_WIDTH  = cpp_pkg::SCREEN_WIDTH_DEF,
    parameter int SCREEN_HEIGHT = cpp_pkg::SCREEN_HEIGHT_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_in_valid,
    output logic                             o_in_ready,
    input  cpp_pkg::t_in                     i_in_data,
    output logic                             o_out_valid,
    input  logic                             i_out_ready,
    output cpp_pkg::t_out                    o_out_data,
    input  logic                             i_cfg_we,
    input  logic [cpp_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [cpp_pkg::CFG_W-1:0]        i_cfg_data
);

    localparam int PRE   = 8;
    localparam int TOTAL = PRE + cpp_pkg::DIV_LAT;
    localparam int WW    = cpp_pkg::WIDE_W;
    localparam int VIS_STAGE = 5;

    localparam logic signed [WW-1:0] K_3W = WW'(3 * SCREEN_WIDTH);
    localparam logic signed [WW-1:0] K_4H = WW'(4 * SCREEN_HEIGHT);
    localparam logic signed [WW-1:0] K_H  = WW'(SCREEN_HEIGHT);

    typedef struct packed {
        logic       vis;
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } t_side;

    logic signed [15:0] r_cam_x, r_cam_y, r_cam_z;
    logic signed [15:0] r_sin_yaw, r_cos_yaw, r_sin_pitch, r_cos_pitch;

    logic        r_vld  [TOTAL];
    t_side       r_side [TOTAL];
    logic        w_en;

    assign w_en       = !r_vld[TOTAL-1] || i_out_ready;
    assign o_in_ready = w_en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cam_x     <= '0;
            r_cam_y     <= '0;
            r_cam_z     <= '0;
            r_sin_yaw   <= '0;
            r_cos_yaw   <= 16'sd16384;
            r_sin_pitch <= '0;
            r_cos_pitch <= 16'sd16384;
        end else if (i_cfg_we) begin
            case (cpp_pkg::t_reg_idx'(i_cfg_idx))
                cpp_pkg::REG_CAM_X:     r_cam_x     <= $signed(i_cfg_data);
                cpp_pkg::REG_CAM_Y:     r_cam_y     <= $signed(i_cfg_data);
                cpp_pkg::REG_CAM_Z:     r_cam_z     <= $signed(i_cfg_data);
                cpp_pkg::REG_SIN_YAW:   r_sin_yaw   <= $signed(i_cfg_data);
                cpp_pkg::REG_COS_YAW:   r_cos_yaw   <= $signed(i_cfg_data);
                cpp_pkg::REG_SIN_PITCH: r_sin_pitch <= $signed(i_cfg_data);
                cpp_pkg::REG_COS_PITCH: r_cos_pitch <= $signed(i_cfg_data);
                default: ;
            endcase
        end
    end

    // valid line
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < TOTAL; k++) r_vld[k] <= 1'b0;
        end else if (w_en) begin
            r_vld[0] <= i_in_valid;
            for (int k = 1; k < TOTAL; k++) r_vld[k] <= r_vld[k-1];
        end
    end

    // S1: offset from camera
    logic signed [16:0] r1_dx, r1_dy, r1_dz;
    // S2: yaw and pitch products
    logic signed [32:0] r2_zsy, r2_xcy, r2_zcy, r2_xsy, r2_ysp, r2_ycp;
    // S3: after yaw
    logic signed [33:0] r3_x1, r3_z1;
    logic signed [32:0] r3_ysp, r3_ycp;
    // S4: pitch products
    logic signed [49:0] r4_z1cp, r4_z1sp;
    logic signed [32:0] r4_ysp, r4_ycp;
    logic signed [33:0] r4_x1;
    // S5: after pitch
    logic signed [50:0] r5_z2, r5_y2;
    logic signed [33:0] r5_x1;
    // S6: scaled terms
    logic signed [WW-1:0] r6_tz, r6_tx, r6_u, r6_den;
    // S7: numerators
    logic signed [WW-1:0] r7_nx, r7_ny, r7_den;
    // S8: divider operands
    cpp_pkg::t_div_in r8_opx, r8_opy;

    logic signed [WW-1:0] w_z2, w_y2, w_x1;
    assign w_z2 = WW'(r5_z2);
    assign w_y2 = WW'(r5_y2);
    assign w_x1 = WW'(r5_x1);

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r1_dx <= 17'(i_in_data.pt_x) - 17'(r_cam_x);
            r1_dy <= 17'(i_in_data.pt_y) - 17'(r_cam_y);
            r1_dz <= 17'(i_in_data.pt_z) - 17'(r_cam_z);

            r2_zsy <= r1_dz * r_sin_yaw;
            r2_xcy <= r1_dx * r_cos_yaw;
            r2_zcy <= r1_dz * r_cos_yaw;
            r2_xsy <= r1_dx * r_sin_yaw;
            r2_ysp <= r1_dy * r_sin_pitch;
            r2_ycp <= r1_dy * r_cos_pitch;

            r3_x1  <= 34'(r2_zsy) + 34'(r2_xcy);
            r3_z1  <= 34'(r2_zcy) - 34'(r2_xsy);
            r3_ysp <= r2_ysp;
            r3_ycp <= r2_ycp;

            r4_z1cp <= r3_z1 * r_cos_pitch;
            r4_z1sp <= r3_z1 * r_sin_pitch;
            r4_ysp  <= r3_ysp;
            r4_ycp  <= r3_ycp;
            r4_x1   <= r3_x1;

            r5_z2 <= 51'(r4_z1cp) - (51'(r4_ysp) <<< 14);
            r5_y2 <= 51'(r4_z1sp) + (51'(r4_ycp) <<< 14);
            r5_x1 <= r4_x1;

            r6_tz  <= w_z2 * K_3W;
            r6_tx  <= (w_x1 * K_4H) <<< 14;
            r6_u   <= (w_z2 <<< 1) + w_z2 - (w_y2 <<< 2);
            r6_den <= (w_z2 <<< 2) + (w_z2 <<< 1);

            r7_nx  <= r6_tz + r6_tx;
            r7_ny  <= r6_u * K_H;
            r7_den <= r6_den;

            r8_opx.neg <= r7_nx[WW-1];
            r8_opx.mag <= r7_nx[WW-1] ? WW'(-r7_nx) : WW'(r7_nx);
            r8_opx.den <= WW'(r7_den);
            r8_opy.neg <= r7_ny[WW-1];
            r8_opy.mag <= r7_ny[WW-1] ? WW'(-r7_ny) : WW'(r7_ny);
            r8_opy.den <= WW'(r7_den);
        end
    end

    // color and visibility travel beside the arithmetic
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_side[0].vis   <= 1'b0;
            r_side[0].red   <= i_in_data.red_in;
            r_side[0].green <= i_in_data.green_in;
            r_side[0].blue  <= i_in_data.blue_in;
            for (int k = 1; k < TOTAL; k++) begin
                if (k == VIS_STAGE) begin
                    r_side[k].vis   <= (r5_z2 > 51'sd0);
                    r_side[k].red   <= r_side[k-1].red;
                    r_side[k].green <= r_side[k-1].green;
                    r_side[k].blue  <= r_side[k-1].blue;
                end else begin
                    r_side[k] <= r_side[k-1];
                end
            end
        end
    end

    logic signed [cpp_pkg::SCR_W-1:0] w_qx, w_qy;

    cpp_div u_div_x (
        .i_clk (i_clk),
        .i_en  (w_en),
        .i_op  (r8_opx),
        .o_q   (w_qx)
    );

    cpp_div u_div_y (
        .i_clk (i_clk),
        .i_en  (w_en),
        .i_op  (r8_opy),
        .o_q   (w_qy)
    );

    assign o_out_valid          = r_vld[TOTAL-1];
    assign o_out_data.visible   = r_side[TOTAL-1].vis;
    assign o_out_data.screen_x  = r_side[TOTAL-1].vis ? w_qx : '0;
    assign o_out_data.screen_y  = r_side[TOTAL-1].vis ? w_qy : '0;
    assign o_out_data.red_out   = r_side[TOTAL-1].red;
    assign o_out_data.green_out = r_side[TOTAL-1].green;
    assign o_out_data.blue_out  = r_side[TOTAL-1].blue;

endmodule

// ===== src/cpp_checker.sv =====
`timescale 1ns / 1ps

module cpp_checker (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_in_valid,
    input  logic                             o_in_ready,
    input  cpp_pkg::t_in                     i_in_data,
    input  logic                             o_out_valid,
    input  logic                             i_out_ready,
    input  cpp_pkg::t_out                    o_out_data,
    input  logic                             i_cfg_we,
    input  logic [cpp_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [cpp_pkg::CFG_W-1:0]        i_cfg_data
);

    // a result that waits is held
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_data))
        else $error("output changed while stalled");

    // culled points carry zero coordinates
    a_cull_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_out_data.visible |->
            o_out_data.screen_x == '0 && o_out_data.screen_y == '0)
        else $error("culled point with nonzero coordinates");

    // input stalls only behind a waiting result
    a_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_ready == (!o_out_valid || i_out_ready))
        else $error("input ready does not follow output stall");

endmodule

bind camera_perspective_project cpp_checker u_cpp_checker (.*);
